// ----- rtl/fors_pkg.sv -----
// fors_pkg: shared types and constants for the first overlapping region search
// holds the region entry layout, command codes and the search state machine type
// no dependencies
package fors_pkg;

   localparam int unsigned ID_W    = 8;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned SIZE_W  = 15;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned SLOT_W  = 6;

   localparam logic [POS_W-1:0] OVERLAP_MARGIN = 16'd128;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
   } region_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ----- rtl/fors_overlap.sv -----
// fors_overlap: combinational overlap test between a query box and one table entry
// compares center distances on both axes against the half size sum plus the margin
// depends on fors_pkg
module fors_overlap (
   input  fors_pkg::region_type query,
   input  fors_pkg::region_type entry,
   output logic                 meet
);
   import fors_pkg::*;

   // wrapped center distance, absolute value; -32768 stays negative
   function automatic logic [POS_W-1:0] center_gap(
      input logic [POS_W-1:0]  pa,
      input logic [SIZE_W-1:0] sa,
      input logic [POS_W-1:0]  pb,
      input logic [SIZE_W-1:0] sb
   );
      logic [POS_W-1:0] ca;
      logic [POS_W-1:0] cb;
      logic [POS_W-1:0] d;
      ca = pa + {2'b00, sa[SIZE_W-1:1]};
      cb = pb + {2'b00, sb[SIZE_W-1:1]};
      d  = ca - cb;
      if (d[POS_W-1]) begin
         d = -d;
      end
      return d;
   endfunction

   // true when gap - (margin + half size sum) is negative
   function automatic logic axis_meet(
      input logic [POS_W-1:0]  gap,
      input logic [SIZE_W-1:0] sa,
      input logic [SIZE_W-1:0] sb
   );
      logic [SIZE_W:0]  sum;
      logic [POS_W-1:0] lim;
      logic [POS_W+1:0] diff;
      sum  = {1'b0, sa} + {1'b0, sb};
      lim  = OVERLAP_MARGIN + {1'b0, sum[SIZE_W:1]};
      diff = {{2{gap[POS_W-1]}}, gap} - {2'b00, lim};
      return diff[POS_W+1];
   endfunction

   logic [POS_W-1:0] gap_x;
   logic [POS_W-1:0] gap_y;

   always_comb begin
      gap_x = center_gap(query.x, query.w, entry.x, entry.w);
      gap_y = center_gap(query.y, query.h, entry.y, entry.h);
      meet  = axis_meet(gap_x, query.w, entry.w) & axis_meet(gap_y, query.h, entry.h);
   end

endmodule

// ----- rtl/first_overlapping_region_search.sv -----
// first_overlapping_region_search: region table with a first-overlap box search
// table in one synchronous memory, walked one entry a cycle; uses fors_pkg, fors_overlap
//
//   channel  ports                          transaction at edge
//   req      start/busy + req_* fields      start && !busy
//   rsp      rsp_strobe + rsp_* fields      every cycle rsp_strobe is high
//   csr      csr_valid/csr_ready, csr_wdata csr_valid && csr_ready (ready always high)
//
// a write is done at acceptance; busy stays low
// a query holds busy while entries are read in order from entry zero until the first hit or,
// on a miss, the last searched entry is checked; each table read is registered before its check
// a query with a searched count of zero answers the cycle after it is accepted
// the result is strobed for one cycle and may overlap acceptance of the next transaction
// reset is synchronous and clears control state only; table contents are undefined until written
module first_overlapping_region_search #(
   parameter int unsigned MAX_REGIONS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [fors_pkg::SLOT_W-1:0]  req_entry_index,
   input  logic [fors_pkg::ID_W-1:0]    req_region_id,
   input  logic signed [fors_pkg::POS_W-1:0] req_box_x,
   input  logic signed [fors_pkg::POS_W-1:0] req_box_y,
   input  logic [fors_pkg::SIZE_W-1:0]  req_box_width,
   input  logic [fors_pkg::SIZE_W-1:0]  req_box_height,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic [fors_pkg::ID_W-1:0]    rsp_found_id,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [fors_pkg::COUNT_W-1:0] csr_wdata
);
   import fors_pkg::*;

   localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    iss_ff, iss_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                chk_last_ff, chk_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   region_type          query_ff, query_in;
   region_type          rd_data_ff;
   region_type          req_entry;
   region_type          mem_q [MAX_REGIONS];

   logic                accept;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_idx;
   logic [CNT_W-1:0]    limit_now;
   logic                meet;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_found_id = rsp_id_ff;

   assign req_entry = '{id: req_region_id, x: req_box_x, y: req_box_y,
                        w: req_box_width, h: req_box_height};

   // searched count, clipped to the table size
   assign limit_now = (32'(count_ff) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS) : CNT_W'(count_ff);

   assign wr_en  = accept && (req_kind == KIND_WRITE) && (32'(req_entry_index) < MAX_REGIONS);
   assign wr_idx = IDX_W'(req_entry_index);
   assign rd_idx = iss_ff[IDX_W-1:0];

   fors_overlap u_overlap (
      .query (query_ff),
      .entry (rd_data_ff),
      .meet  (meet)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_QUERY) && (limit_now != '0)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff && (meet || chk_last_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      query_in     = query_ff;
      limit_in     = limit_ff;
      iss_in       = iss_ff;
      chk_vld_in   = 1'b0;
      chk_last_in  = chk_last_ff;
      rd_en        = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_id_in    = rsp_id_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_QUERY)) begin
               query_in = req_entry;
               limit_in = limit_now;
               iss_in   = '0;
               if (limit_now == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_id_in    = '0;
               end
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff && meet) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_id_in    = rd_data_ff.id;
            end else if (chk_vld_ff && chk_last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_id_in    = '0;
            end else if (iss_ff < limit_ff) begin
               rd_en       = 1'b1;
               chk_vld_in  = 1'b1;
               chk_last_in = (CNT_W'(iss_ff + 1'b1) == limit_ff);
               iss_in      = CNT_W'(iss_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= '0;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         chk_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         chk_last_ff  <= chk_last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      query_ff   <= query_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_id_ff  <= rsp_id_in;
   end

   // region table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_idx] <= req_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_idx];
      end
   end

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || (start && req_kind == KIND_QUERY)))
      else $error("result strobe without a query in progress");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_found_id == '0))
      else $error("miss result carries a nonzero id");

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == ST_SCAN))
      else $error("table read data checked outside a scan");

   a_iss_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iss_ff <= limit_ff))
      else $error("scan address ran past the searched count");

endmodule

// ----- tb/sv/tb_first_overlapping_region_search.sv -----
// tb_first_overlapping_region_search: self-checking bench for the region table box search
// drives table writes, box searches and count settings, predicts every search result locally
// depends on fors_pkg and first_overlapping_region_search
module tb_first_overlapping_region_search;
   import fors_pkg::*;

   localparam int unsigned TABLE_DEPTH   = 64;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int          MARGIN        = 128;
   localparam int unsigned IDLE_SOME     = 38;
   localparam int unsigned IDLE_MOST     = 86;
   localparam int unsigned IDLE_NONE     = 0;

   typedef enum logic [1:0] {
      ACT_ITEM,
      ACT_COUNT,
      ACT_SETTLE
   } action_type;

   typedef struct {
      action_type         action;
      int unsigned        idle_pct;
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      region_type         box;
      logic [COUNT_W-1:0] count;
   } plan_type;

   typedef struct packed {
      logic            hit;
      logic [ID_W-1:0] id;
   } search_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_kind = KIND_WRITE;
   logic [SLOT_W-1:0]         req_entry_index = '0;
   logic [ID_W-1:0]           req_region_id = '0;
   logic signed [POS_W-1:0]   req_box_x = '0;
   logic signed [POS_W-1:0]   req_box_y = '0;
   logic [SIZE_W-1:0]         req_box_width = '0;
   logic [SIZE_W-1:0]         req_box_height = '0;
   logic                      rsp_strobe;
   logic                      rsp_hit;
   logic [ID_W-1:0]           rsp_found_id;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [COUNT_W-1:0]        csr_wdata = '0;

   plan_type          plan_q[$];
   search_result_type expected_q[$];

   // predictor state
   region_type         region_model[TABLE_DEPTH];
   logic [COUNT_W-1:0] count_model = '0;

   // generator view of the table, used to aim searches at stored regions
   region_type  planned_regions[TABLE_DEPTH];
   int unsigned planned_count = 0;

   int unsigned settle_count = 0;
   int unsigned errors = 0;
   int unsigned searches = 0;
   int unsigned table_writes = 0;
   int unsigned count_writes = 0;
   int unsigned hits_seen = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   first_overlapping_region_search #(
      .MAX_REGIONS(TABLE_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_entry_index(req_entry_index),
      .req_region_id  (req_region_id),
      .req_box_x      (req_box_x),
      .req_box_y      (req_box_y),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_found_id   (rsp_found_id),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   // wrapped center distance on one axis; a gap of -32768 stays negative
   function automatic int center_gap(logic [POS_W-1:0] pa, logic [SIZE_W-1:0] sa,
                                     logic [POS_W-1:0] pb, logic [SIZE_W-1:0] sb);
      logic signed [POS_W-1:0] gap;
      gap = (pa + POS_W'(sa >> 1)) - (pb + POS_W'(sb >> 1));
      if (gap < 0) gap = -gap;
      return int'(gap);
   endfunction

   function automatic search_result_type search_first_overlap(region_type probe);
      search_result_type res;
      int unsigned       n;
      int unsigned       i;
      int                half_w;
      int                half_h;
      res = '0;
      n = (count_model > TABLE_DEPTH) ? TABLE_DEPTH : count_model;
      for (i = 0; i < n && !res.hit; i++) begin
         half_w = (int'(probe.w) + int'(region_model[i].w)) / 2;
         half_h = (int'(probe.h) + int'(region_model[i].h)) / 2;
         if (center_gap(probe.x, probe.w, region_model[i].x, region_model[i].w)
                - (MARGIN + half_w) < 0 &&
             center_gap(probe.y, probe.h, region_model[i].y, region_model[i].h)
                - (MARGIN + half_h) < 0) begin
            res.hit = 1'b1;
            res.id  = region_model[i].id;
         end
      end
      return res;
   endfunction

   function automatic region_type make_box(logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                                           logic [POS_W-1:0] y, logic [SIZE_W-1:0] w,
                                           logic [SIZE_W-1:0] h);
      region_type box;
      box.id = id;
      box.x  = x;
      box.y  = y;
      box.w  = w;
      box.h  = h;
      return box;
   endfunction

   // mostly small boxes, now and then one of any size
   function automatic logic [SIZE_W-1:0] random_size();
      if ($urandom_range(99) < 80) return SIZE_W'($urandom_range(511));
      return SIZE_W'($urandom_range(32767));
   endfunction

   function automatic region_type random_box();
      return make_box(ID_W'($urandom_range(255)), POS_W'($urandom), POS_W'($urandom),
                      random_size(), random_size());
   endfunction

   task automatic plan_write(logic [SLOT_W-1:0] slot, region_type box, int unsigned idle);
      plan_type p;
      p.action   = ACT_ITEM;
      p.idle_pct = idle;
      p.kind     = KIND_WRITE;
      p.slot     = slot;
      p.box      = box;
      p.count    = '0;
      plan_q.push_back(p);
      planned_regions[slot] = box;
   endtask

   task automatic plan_query(region_type box, int unsigned idle);
      plan_type p;
      p.action   = ACT_ITEM;
      p.idle_pct = idle;
      p.kind     = KIND_QUERY;
      p.slot     = SLOT_W'($urandom);
      p.box      = box;
      p.count    = '0;
      plan_q.push_back(p);
   endtask

   task automatic plan_settle();
      plan_type p;
      p.action   = ACT_SETTLE;
      p.idle_pct = 0;
      p.kind     = KIND_WRITE;
      p.slot     = '0;
      p.box      = '0;
      p.count    = '0;
      plan_q.push_back(p);
   endtask

   // the count only changes once the block has gone quiet
   task automatic plan_count(logic [COUNT_W-1:0] value);
      plan_type p;
      plan_settle();
      p.action   = ACT_COUNT;
      p.idle_pct = 0;
      p.kind     = KIND_WRITE;
      p.slot     = '0;
      p.box      = '0;
      p.count    = value;
      plan_q.push_back(p);
      planned_count = value;
   endtask

   // only used once every slot holds a region
   task automatic plan_random(int unsigned n, int unsigned idle);
      int unsigned i;
      int unsigned sel;
      int unsigned searched;
      int unsigned j;
      region_type  box;
      for (i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         searched = (planned_count > TABLE_DEPTH) ? TABLE_DEPTH : planned_count;
         if (sel < 25) begin
            plan_write(SLOT_W'($urandom_range(TABLE_DEPTH - 1)), random_box(), idle);
         end else if (sel < 75 && searched != 0) begin
            // box placed near a stored region, so the walk may stop at or before it
            j = $urandom_range(searched - 1);
            box = make_box(ID_W'($urandom_range(255)),
                           planned_regions[j].x + POS_W'($urandom_range(400)) - POS_W'(200),
                           planned_regions[j].y + POS_W'($urandom_range(400)) - POS_W'(200),
                           SIZE_W'($urandom_range(300)), SIZE_W'($urandom_range(300)));
            plan_query(box, idle);
         end else begin
            plan_query(random_box(), idle);
         end
      end
   endtask

   always @(posedge clock) begin : driver
      logic     next_start;
      logic     next_csr;
      plan_type head;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         next_start = start;
         next_csr   = csr_valid;
         if (start && !busy) begin
            head = plan_q.pop_front();
            if (head.kind == KIND_QUERY) begin
               expected_q.push_back(search_first_overlap(head.box));
               searches++;
            end else begin
               region_model[head.slot] = head.box;
               table_writes++;
            end
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            head = plan_q.pop_front();
            count_model = head.count;
            count_writes++;
            next_csr = 1'b0;
         end
         if (!next_start && !next_csr && plan_q.size() != 0) begin
            head = plan_q[0];
            case (head.action)
               ACT_ITEM: begin
                  if ($urandom_range(99) >= head.idle_pct) begin
                     req_kind        <= head.kind;
                     req_entry_index <= head.slot;
                     req_region_id   <= head.box.id;
                     req_box_x       <= head.box.x;
                     req_box_y       <= head.box.y;
                     req_box_width   <= head.box.w;
                     req_box_height  <= head.box.h;
                     next_start = 1'b1;
                  end
               end
               ACT_COUNT: begin
                  csr_wdata <= head.count;
                  next_csr = 1'b1;
               end
               default: begin
                  if (expected_q.size() == 0 && !busy) begin
                     if (settle_count == SETTLE_CYCLES) begin
                        void'(plan_q.pop_front());
                        settle_count = 0;
                     end else begin
                        settle_count++;
                     end
                  end else begin
                     settle_count = 0;
                  end
               end
            endcase
         end
         start     <= next_start;
         csr_valid <= next_csr;
      end
   end

   always @(posedge clock) begin : monitor
      search_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $error("result with no search pending: hit %0b found_id %0d",
                   rsp_hit, rsp_found_id);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0b actual %0b", want.hit, rsp_hit);
               errors++;
            end
            if (rsp_found_id !== want.id) begin
               $error("found_id: expected %0d actual %0d", want.id, rsp_found_id);
               errors++;
            end
            if (want.hit) hits_seen++;
         end
      end
   end

   initial begin : stimulus
      int unsigned i;

      // empty search range right after reset
      plan_query(make_box(8'h12, 16'h0000, 16'h0000, 15'd0, 15'd0), IDLE_SOME);
      plan_write(6'd0, make_box(8'hFF, 16'h8000, 16'h8000, 15'd0, 15'd0), IDLE_SOME);
      plan_write(6'd1, make_box(8'h00, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF), IDLE_SOME);
      plan_write(6'd2, make_box(8'h5A, 16'h0000, 16'h0000, 15'd100, 15'd100), IDLE_SOME);
      // 16'hFC18 is -1000
      plan_write(6'd3, make_box(8'hA5, 16'd1000, 16'hFC18, 15'd1, 15'd1), IDLE_SOME);
      plan_count(7'd4);
      // center gap of exactly -32768 against the first entry
      plan_query(make_box(8'h00, 16'h0000, 16'h0000, 15'd0, 15'd0), IDLE_SOME);
      plan_query(make_box(8'hFF, 16'd16384, 16'hC000, 15'd0, 15'd0), IDLE_SOME);
      plan_query(make_box(8'h81, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF), IDLE_SOME);
      plan_query(make_box(8'h7E, 16'h8000, 16'h8000, 15'd0, 15'd0), IDLE_SOME);
      // hit on an entry whose id is zero
      plan_query(make_box(8'h33, 16'd60, 16'd40, 15'd10, 15'd10), IDLE_SOME);
      plan_query(make_box(8'hCC, 16'd1000, 16'hFC18, 15'd1, 15'd1), IDLE_SOME);
      // one inside and one on the margin edge of the last entry
      plan_query(make_box(8'h01, 16'd1127, 16'hFC18, 15'd0, 15'd0), IDLE_SOME);
      plan_query(make_box(8'h02, 16'd1128, 16'hFC18, 15'd0, 15'd0), IDLE_SOME);
      plan_count(7'd1);
      plan_query(make_box(8'h44, 16'h0000, 16'h0000, 15'd0, 15'd0), IDLE_SOME);

      for (i = 4; i < TABLE_DEPTH; i++) plan_write(SLOT_W'(i), random_box(), IDLE_SOME);
      plan_count(7'd64);
      plan_random(110, IDLE_SOME);

      // count beyond the table size searches the whole table
      plan_count(7'd127);
      plan_random(100, IDLE_MOST);
      plan_count(7'd1);
      plan_random(25, IDLE_MOST);

      plan_count(COUNT_W'($urandom_range(63, 2)));
      plan_random(90, IDLE_NONE);
      plan_count(7'd0);
      plan_random(12, IDLE_NONE);
      plan_count(7'd100);
      plan_random(20, IDLE_NONE);
      plan_settle();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d search results never arrived", expected_q.size());
         errors++;
      end
      $display("covered %0d table writes and %0d searches (%0d hits)",
               table_writes, searches, hits_seen);
      $display("search count set %0d times, from 0 up to 127", count_writes);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
